// ===== rtl/updc_pkg.sv =====
`default_nettype none

package updc_pkg;

    // characters the decoder and the path checker look for
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       done_res;
        logic       safe;
    } t_out_item;

    // one decoded step, handed from the decoder to the path checker
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] dec_byte;
        logic       last;
        logic       dec_err;
    } t_token;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.bad = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
            h.val = 4'(c[2:0]) + 4'd9;
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/updc_front.sv =====
`default_nettype none

module updc_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire updc_pkg::t_in_item i_item,
    input  wire                    i_take,
    output updc_pkg::t_token       o_token
);
    import updc_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_high, n_high;
    t_hex       hx;
    logic       dec_valid;
    logic [7:0] dec_byte;
    logic       dec_err;

    always_comb begin
        hx        = hex_digit(i_item.in_byte);
        n_phase   = PH_PLAIN;
        n_high    = r_high;
        dec_valid = 1'b0;
        dec_byte  = 8'd0;
        dec_err   = 1'b0;
        unique case (r_phase)
            PH_HIGH: begin
                if (hx.bad) begin
                    dec_err = 1'b1;
                end else begin
                    n_high  = hx.val;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                if (hx.bad) begin
                    dec_err = 1'b1;
                end else begin
                    dec_valid = 1'b1;
                    dec_byte  = {r_high, hx.val};
                end
            end
            default: begin
                if (i_item.in_byte == CH_PERCENT) begin
                    n_phase = PH_HIGH;
                end else begin
                    dec_valid = 1'b1;
                    dec_byte  = i_item.in_byte;
                end
            end
        endcase
        // escape cut off by the end of the path
        if (i_item.last) begin
            if (n_phase != PH_PLAIN) begin
                dec_err = 1'b1;
            end
            n_phase = PH_PLAIN;
            n_high  = 4'd0;
        end
    end

    assign o_token.byte_valid = dec_valid;
    assign o_token.dec_byte   = dec_byte;
    assign o_token.last       = i_item.last;
    assign o_token.dec_err    = dec_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_high  <= 4'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_high  <= n_high;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/updc_queue.sv =====
`default_nettype none

module updc_queue #(
    parameter int DEPTH = 2
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_wr,
    input  wire updc_pkg::t_token  i_wr_data,
    output logic                   o_full,
    input  wire                    i_rd,
    output updc_pkg::t_token       o_rd_data,
    output logic                   o_valid
);
    import updc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_token         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en, rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != CW'(DEPTH)) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/updc_back.sv =====
`default_nettype none

module updc_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire updc_pkg::t_token  i_token,
    input  wire                    i_token_valid,
    output logic                   o_token_take,
    output updc_pkg::t_out_item    o_out_item,
    output logic                   o_empty,
    input  wire                    i_pop
);
    import updc_pkg::*;

    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } t_seg;

    logic      r_rejected, n_rejected;
    logic      r_seen, n_seen;
    t_seg      r_seg, n_seg;
    t_out_item r_out, n_out;
    logic      r_out_valid;
    logic      take;
    logic      bad;

    assign take         = i_token_valid && (!r_out_valid || i_pop);
    assign o_token_take = take;
    assign o_out_item   = r_out;
    assign o_empty      = !r_out_valid;

    always_comb begin
        n_rejected = r_rejected | i_token.dec_err;
        n_seen     = r_seen;
        n_seg      = r_seg;
        if (i_token.byte_valid) begin
            if (!r_seen) begin
                n_seen = 1'b1;
                if (i_token.dec_byte != CH_SLASH) begin
                    n_rejected = 1'b1;
                end
            end
            if (i_token.dec_byte == CH_BSLASH || i_token.dec_byte == CH_COLON ||
                i_token.dec_byte == CH_NUL) begin
                n_rejected = 1'b1;
            end
            if (i_token.dec_byte == CH_SLASH) begin
                if (r_seg == SEG_DOTDOT) begin
                    n_rejected = 1'b1;
                end
                n_seg = SEG_EMPTY;
            end else if (i_token.dec_byte == CH_DOT) begin
                unique case (r_seg)
                    SEG_EMPTY:  n_seg = SEG_DOT;
                    SEG_DOT:    n_seg = SEG_DOTDOT;
                    default:    n_seg = SEG_OTHER;
                endcase
            end else begin
                n_seg = SEG_OTHER;
            end
        end
        bad              = n_rejected || !n_seen || (n_seg == SEG_DOTDOT);
        n_out.byte_valid = i_token.byte_valid;
        n_out.out_byte   = i_token.dec_byte;
        n_out.done_res   = i_token.last;
        n_out.safe       = i_token.last && !bad;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rejected  <= 1'b0;
            r_seen      <= 1'b0;
            r_seg       <= SEG_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                if (i_token.last) begin
                    r_rejected <= 1'b0;
                    r_seen     <= 1'b0;
                    r_seg      <= SEG_EMPTY;
                end else begin
                    r_rejected <= n_rejected;
                    r_seen     <= n_seen;
                    r_seg      <= n_seg;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_safe_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.safe || r_out.done_res))
        else $error("verdict on a result that is not the last");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |-> (r_out.out_byte == 8'd0))
        else $error("byte present without byte_valid");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_token.last) |=> (!r_rejected && !r_seen && r_seg == SEG_EMPTY))
        else $error("checker state not cleared after the last byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/url_path_decode_and_check_core.sv =====
`default_nettype none

// percent-decoding request path checker. raw path bytes enter through a queue-style
// port (push/full), one byte per transfer, with a last flag on the final byte. every
// accepted byte gives exactly one result (empty/pop): the decoded byte when one is
// complete, and on the last byte a verdict (safe = 1 for an acceptable path). a path
// is rejected for a malformed or unfinished escape, no decoded bytes, a first byte
// other than '/', a decoded backslash, colon or nul, or a segment that is exactly "..".
// sustained rate is one byte per clock while results are popped as they appear; a
// byte's result goes through the token queue, written at the transfer edge, and the
// checker's output register before it is on the result ports and can be popped.
// state clears itself after each last byte, so paths can follow back to back.
module url_path_decode_and_check_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // raw path byte side
    input  wire                    push,
    input  wire updc_pkg::t_in_item i_in_item,
    output logic                   full,
    // result side
    output logic                   empty,
    input  wire                    pop,
    output updc_pkg::t_out_item    o_out_item
);
    import updc_pkg::*;

    t_token front_token;
    t_token q_token;
    logic   q_full;
    logic   q_valid;
    logic   back_take;
    logic   in_take;

    // front side: accept while the token queue has room
    assign full    = q_full;
    assign in_take = push && !q_full;

    // percent decoder: escape phase and pending high nibble
    updc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_take  (in_take),
        .o_token (front_token)
    );

    // short queue so the decoder and the checker stall independently
    updc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (in_take),
        .i_wr_data (front_token),
        .o_full    (q_full),
        .i_rd      (back_take),
        .o_rd_data (q_token),
        .o_valid   (q_valid)
    );

    // path checker with the result register; takes a token whenever the
    // result slot is free or being popped in the same cycle
    updc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token       (q_token),
        .i_token_valid (q_valid),
        .o_token_take  (back_take),
        .o_out_item    (o_out_item),
        .o_empty       (empty),
        .i_pop         (pop)
    );

endmodule

`default_nettype wire
